// ----- src/utf8_to_ucs2_decoder_core_assert.svh -----
// Assertion macros used by the checker file utd_checker.sv.
`ifndef UTF8_TO_UCS2_DECODER_CORE_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_CORE_ASSERT_SVH

// Clocked assertion, switched off while reset is held.
`define UTD_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define UTD_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ----- src/utd_pkg.sv -----
`default_nettype none

package utd_pkg;

  // Final status codes of a string
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FORBIDDEN = 3'd1,
    ST_BAD_LEAD  = 3'd2,
    ST_BAD_CONT  = 3'd3,
    ST_TRUNC     = 3'd4,
    ST_SURROGATE = 3'd5
  } status_t;

  // Code point range and special values
  localparam logic [15:0] SURR_LO = 16'hD800;
  localparam logic [15:0] SURR_HI = 16'hDFFF;
  localparam logic [15:0] BOM_CP  = 16'hFEFF;
  localparam logic [2:0]  BOM_LEN = 3'd3;

  // Decoder state carried from byte to byte. The accumulator keeps the low
  // 16 bits of the code point; big is set once any higher bit is nonzero.
  typedef struct packed {
    logic [2:0]  pending;
    logic [15:0] accum;
    logic        big;
    logic [2:0]  seq_len;
    logic        at_start;
    logic        halted;
    status_t     status;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_RESET = '{
    pending:  3'd0,
    accum:    16'd0,
    big:      1'b0,
    seq_len:  3'd0,
    at_start: 1'b1,
    halted:   1'b0,
    status:   ST_OK
  };

  // Result produced by one byte
  typedef struct packed {
    logic        valid;
    logic [15:0] code_unit;
    logic        has_char;
    status_t     status;
    logic        string_done;
  } dec_result_t;

endpackage

`default_nettype wire

// ----- src/utd_step.sv -----
`default_nettype none

module utd_step
  import utd_pkg::*;
(
  input  dec_state_t  state_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output dec_state_t  state_o,
  output dec_result_t result_o
);

  always_comb begin
    dec_state_t  ns;
    logic [2:0]  len;
    logic [6:0]  head;
    logic        complete;
    logic        has;
    logic [15:0] unit;
    status_t     fin;

    ns       = state_i;
    len      = 3'd0;
    head     = 7'd0;
    complete = 1'b0;
    has      = 1'b0;
    unit     = 16'd0;
    fin      = ST_OK;

    if (state_i.halted) begin
      // after an error only the remaining sequence count runs down
      if (state_i.pending != 3'd0) begin
        ns.pending = state_i.pending - 3'd1;
      end
    end else if (state_i.pending == 3'd0) begin
      // lead byte classification
      case (byte_i) inside
        8'hC0, 8'hC1, 8'hF5, 8'hFF: begin
          ns.halted  = 1'b1;
          ns.status  = ST_FORBIDDEN;
          ns.pending = 3'd0;
        end
        [8'h00:8'h7F]: begin
          len  = 3'd1;
          head = byte_i[6:0];
        end
        [8'hC2:8'hDF]: begin
          len  = 3'd2;
          head = {2'b00, byte_i[4:0]};
        end
        [8'hE0:8'hEF]: begin
          len  = 3'd3;
          head = {3'b000, byte_i[3:0]};
        end
        [8'hF0:8'hF4], [8'hF6:8'hF7]: begin
          len  = 3'd4;
          head = {4'b0000, byte_i[2:0]};
        end
        [8'hF8:8'hFB]: begin
          len  = 3'd5;
          head = {5'b00000, byte_i[1:0]};
        end
        [8'hFC:8'hFD]: begin
          len  = 3'd6;
          head = {6'b000000, byte_i[0]};
        end
        default: begin
          ns.halted  = 1'b1;
          ns.status  = ST_BAD_LEAD;
          ns.pending = 3'd0;
        end
      endcase

      if (len != 3'd0) begin
        ns.seq_len = len;
        ns.accum   = {9'd0, head};
        ns.big     = 1'b0;
        if (len == 3'd1) begin
          complete = 1'b1;
        end else if (last_i) begin
          ns.halted  = 1'b1;
          ns.status  = ST_TRUNC;
          ns.pending = 3'd0;
        end else begin
          ns.pending = len - 3'd1;
        end
      end
    end else begin
      // continuation byte
      ns.pending = state_i.pending - 3'd1;
      if (byte_i[7:6] != 2'b10) begin
        // count is kept so truncation can still be detected
        ns.halted = 1'b1;
        ns.status = ST_BAD_CONT;
      end else begin
        ns.accum = {state_i.accum[9:0], byte_i[5:0]};
        ns.big   = state_i.big | (state_i.accum[15:10] != 6'd0);
        if (ns.pending == 3'd0) begin
          complete = 1'b1;
        end else if (last_i) begin
          ns.halted  = 1'b1;
          ns.status  = ST_TRUNC;
          ns.pending = 3'd0;
        end
      end
    end

    // finished code point
    if (complete) begin
      if (!ns.big && ns.accum >= SURR_LO && ns.accum <= SURR_HI) begin
        ns.halted  = 1'b1;
        ns.status  = ST_SURROGATE;
        ns.pending = 3'd0;
      end else if (state_i.at_start && ns.seq_len == BOM_LEN && !ns.big &&
                   ns.accum == BOM_CP) begin
        // leading byte order mark is dropped
        has = 1'b0;
      end else if (!ns.big) begin
        has  = 1'b1;
        unit = ns.accum;
      end
      ns.at_start = 1'b0;
      ns.accum    = 16'd0;
      ns.big      = 1'b0;
      ns.seq_len  = 3'd0;
    end

    // end of string: report status and start over
    if (last_i) begin
      fin = ns.status;
      if (ns.halted && ns.status == ST_BAD_CONT && ns.pending != 3'd0) begin
        fin = ST_TRUNC;
      end
      result_o.valid       = 1'b1;
      result_o.code_unit   = unit;
      result_o.has_char    = has;
      result_o.status      = fin;
      result_o.string_done = 1'b1;
      state_o              = DEC_STATE_RESET;
    end else begin
      result_o.valid       = has;
      result_o.code_unit   = unit;
      result_o.has_char    = has;
      result_o.status      = ST_OK;
      result_o.string_done = 1'b0;
      state_o              = ns;
    end
  end

endmodule

`default_nettype wire

// ----- src/utf8_to_ucs2_decoder_core.sv -----
// UTF-8 to UCS-2 stream decoder.
// Input channel: one byte per transfer (in_byte_in) with in_last_byte set on
// the final byte of a string. Result channel: out_code_unit/out_has_char for
// a decoded basic plane character, out_status and out_string_done on the
// result for the final byte. A byte that neither ends the string nor
// completes an emitted character produces no result transfer.
// Pipeline: an input register, then the decode step, then the result
// register; a byte's result is presented from the result register once
// the byte has passed the input register. One byte is taken per cycle
// while in_stall is low; the only loop is the update of the decoder
// state in the step logic.
// While out_stall holds a waiting result the result register holds, the
// input register still takes one byte, and in_stall rises once it is full.
// Reset (rst_n low at a clock edge) empties both registers and returns the
// decoder to the start of a new string.
`default_nettype none

module utf8_to_ucs2_decoder_core
  import utd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_in,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_code_unit,
  output logic             out_has_char,
  output logic [2:0]       out_status,
  output logic             out_string_done
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  dec_state_t  state_r;
  dec_state_t  state_nxt;
  dec_result_t res;
  logic        out_valid_r;
  logic [15:0] out_code_unit_r;
  logic        out_has_char_r;
  status_t     out_status_r;
  logic        out_string_done_r;
  logic        adv;

  // the step advances whenever the result register is free or drains
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;

  utd_step u_step (
    .state_i  (state_r),
    .byte_i   (s1_byte_r),
    .last_i   (s1_last_r),
    .state_o  (state_nxt),
    .result_o (res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= DEC_STATE_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r && res.valid;
        if (s1_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte_in;
      s1_last_r <= in_last_byte;
    end
    if (adv && s1_valid_r && res.valid) begin
      out_code_unit_r   <= res.code_unit;
      out_has_char_r    <= res.has_char;
      out_status_r      <= res.status;
      out_string_done_r <= res.string_done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_unit   = out_code_unit_r;
  assign out_has_char    = out_has_char_r;
  assign out_status      = 3'(out_status_r);
  assign out_string_done = out_string_done_r;

endmodule

`default_nettype wire

// ----- src/utd_checker.sv -----
`default_nettype none
`include "utf8_to_ucs2_decoder_core_assert.svh"

module utd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_code_unit,
  input wire logic        out_has_char,
  input wire logic [2:0]  out_status,
  input wire logic        out_string_done
);

  // a stalled result holds until its transfer
  `UTD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_code_unit) && $stable(out_has_char) && $stable(out_status) && $stable(out_string_done), "stalled result changed")

  // a mid-string result always carries a character and no status
  `UTD_ASSERT(a_mid_char, clk, rst_n, out_valid && !out_string_done |-> out_has_char && out_status == 3'd0, "mid-string result without character")

  // no character means a zero code unit
  `UTD_ASSERT(a_no_char_zero, clk, rst_n, out_valid && !out_has_char |-> out_code_unit == 16'd0, "code unit set without character")

  // surrogate code points never come out
  `UTD_ASSERT(a_no_surrogate, clk, rst_n, out_valid && out_has_char |-> (out_code_unit < 16'hD800 || out_code_unit > 16'hDFFF), "surrogate emitted")

  // reset empties the result register
  `UTD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind utf8_to_ucs2_decoder_core utd_checker u_utd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_code_unit   (out_code_unit),
  .out_has_char    (out_has_char),
  .out_status      (out_status),
  .out_string_done (out_string_done)
);

`default_nettype wire

// ----- tb/sv/tb_utf8_to_ucs2_decoder_core.sv -----
`timescale 1ns / 1ps

module tb_utf8_to_ucs2_decoder_core;
  import utd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 550;

  typedef logic [7:0] byte_q_t[$];

  // One result transfer as the decoder should present it
  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_char;
    status_t     status;
    logic        string_done;
  } ucs2_result_t;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_in   = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [15:0] out_code_unit;
  logic        out_has_char;
  logic [2:0]  out_status;
  logic        out_string_done;

  utf8_to_ucs2_decoder_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_in      (in_byte_in),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_unit   (out_code_unit),
    .out_has_char    (out_has_char),
    .out_status      (out_status),
    .out_string_done (out_string_done)
  );

  // Decoder state mirrored by the predictor
  logic [2:0]  dec_pending;
  logic [30:0] dec_accum;
  logic [2:0]  dec_seq_len;
  logic        dec_at_start;
  logic        dec_halted;
  status_t     dec_status;

  ucs2_result_t ucs2_out_q[$];
  ucs2_result_t want;

  int errors          = 0;
  int bytes_sent      = 0;
  int strings_sent    = 0;
  int results_checked = 0;
  int chars_predicted = 0;
  int idle_cycles     = 0;
  int status_seen[6];
  logic no_gaps       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Queue helpers
  // ---------------------------------------------------------------------------
  function automatic void append_byte(ref byte_q_t q, input logic [7:0] b);
    q.insert(q.size(), b);
  endfunction

  function automatic void queue_result(input ucs2_result_t r);
    ucs2_out_q.insert(ucs2_out_q.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_decoder();
    dec_pending  = '0;
    dec_accum    = '0;
    dec_seq_len  = '0;
    dec_at_start = 1'b1;
    dec_halted   = 1'b0;
    dec_status   = ST_OK;
  endfunction

  function automatic void flag_error(input status_t code, input logic keep_count);
    dec_halted = 1'b1;
    dec_status = code;
    if (!keep_count) dec_pending = '0;
  endfunction

  // Advance the decoder by one byte and queue the result it causes, if any
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic         complete;
    logic         has;
    logic [15:0]  unit;
    logic [2:0]   len;
    logic [30:0]  head;
    ucs2_result_t r;
    complete = 1'b0;
    has      = 1'b0;
    unit     = '0;
    len      = '0;
    head     = '0;

    if (dec_halted) begin
      // skipping the rest of a broken string, still counting its bytes
      if (dec_pending != 0) dec_pending--;
    end else if (dec_pending == 0) begin
      // lead byte
      if (b == 8'hC0 || b == 8'hC1 || b == 8'hF5 || b == 8'hFF) begin
        flag_error(ST_FORBIDDEN, 1'b0);
      end else if (b[7] == 1'b0) begin
        len = 3'd1; head = 31'(b);
      end else if (b[7:5] == 3'b110) begin
        len = 3'd2; head = 31'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        len = 3'd3; head = 31'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        len = 3'd4; head = 31'(b[2:0]);
      end else if (b[7:2] == 6'b111110) begin
        len = 3'd5; head = 31'(b[1:0]);
      end else if (b[7:1] == 7'b1111110) begin
        len = 3'd6; head = 31'(b[0]);
      end else begin
        flag_error(ST_BAD_LEAD, 1'b0);
      end
      if (len != 0) begin
        dec_seq_len = len;
        dec_accum   = head;
        if (len == 3'd1) begin
          complete = 1'b1;
        end else if (last) begin
          flag_error(ST_TRUNC, 1'b0);
        end else begin
          dec_pending = len - 3'd1;
        end
      end
    end else begin
      // continuation byte
      dec_pending--;
      if (b[7:6] != 2'b10) begin
        flag_error(ST_BAD_CONT, 1'b1);
      end else begin
        dec_accum = {dec_accum[24:0], b[5:0]};
        if (dec_pending == 0) complete = 1'b1;
        else if (last) flag_error(ST_TRUNC, 1'b0);
      end
    end

    // code point finished: surrogate check, BOM skip, basic plane filter
    if (complete) begin
      if (dec_accum >= 31'(SURR_LO) && dec_accum <= 31'(SURR_HI)) begin
        flag_error(ST_SURROGATE, 1'b0);
      end else if (dec_at_start && dec_seq_len == BOM_LEN && dec_accum == 31'(BOM_CP)) begin
        // leading byte order mark, dropped
      end else if (dec_accum <= 31'h0000_FFFF) begin
        has  = 1'b1;
        unit = dec_accum[15:0];
      end
      dec_at_start = 1'b0;
      dec_accum    = '0;
      dec_seq_len  = '0;
    end

    if (has) chars_predicted++;
    if (last) begin
      // truncation wins over a bad continuation inside the same sequence
      if (dec_halted && dec_status == ST_BAD_CONT && dec_pending != 0) dec_status = ST_TRUNC;
      r.code_unit   = has ? unit : 16'h0000;
      r.has_char    = has;
      r.status      = dec_status;
      r.string_done = 1'b1;
      queue_result(r);
      status_seen[dec_status]++;
      clear_decoder();
    end else if (has) begin
      r.code_unit   = unit;
      r.has_char    = 1'b1;
      r.status      = ST_OK;
      r.string_done = 1'b0;
      queue_result(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!no_gaps && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte_in   <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_string(input byte_q_t s);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
    strings_sent++;
  endtask

  // Result side stalls at random, except in the no-gap stretch
  always @(posedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(0, 99) < 7);
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (ucs2_out_q.size() == 0) begin
        $error("unexpected result transfer: code_unit %h has_char %b status %0d done %b",
               out_code_unit, out_has_char, out_status, out_string_done);
        errors++;
      end else begin
        want = ucs2_out_q.pop_front();
        if (out_code_unit !== want.code_unit) begin
          $error("code_unit: expected %h, got %h", want.code_unit, out_code_unit);
          errors++;
        end
        if (out_has_char !== want.has_char) begin
          $error("has_char: expected %b, got %b", want.has_char, out_has_char);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_string_done !== want.string_done) begin
          $error("string_done: expected %b, got %b", want.string_done, out_string_done);
          errors++;
        end
        results_checked++;
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("utf8_to_ucs2_decoder_core verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_ascii_extremes();
    byte_q_t s;
    s = {8'h00, 8'h7F};
    send_string(s);
  endtask

  task automatic test_bom();
    byte_q_t s;
    s = {8'hEF, 8'hBB, 8'hBF, 8'h41};
    send_string(s);
  endtask

  task automatic test_forbidden_lead();
    byte_q_t s;
    // error, then a byte that must be ignored
    s = {8'hC0, 8'h41};
    send_string(s);
    s = {8'hFF};
    send_string(s);
  endtask

  task automatic test_bad_lead();
    byte_q_t s;
    s = {8'hFE};
    send_string(s);
    s = {8'h80};
    send_string(s);
  endtask

  task automatic test_bad_continuation();
    byte_q_t s;
    // sequence is fully supplied, so the bad continuation stands
    s = {8'hE2, 8'h41, 8'h42};
    send_string(s);
  endtask

  task automatic test_truncation();
    byte_q_t s;
    // ends inside a sequence that already had a bad continuation
    s = {8'hE2, 8'h41};
    send_string(s);
    // lead byte alone at the end
    s = {8'hC3};
    send_string(s);
  endtask

  task automatic test_surrogate();
    byte_q_t s;
    s = {8'hED, 8'hA0, 8'h80};
    send_string(s);
  endtask

  task automatic test_beyond_bmp();
    byte_q_t s;
    // U+1F600 is dropped quietly, the following character still comes out
    s = {8'hF0, 8'h9F, 8'h98, 8'h80, 8'h41};
    send_string(s);
  endtask

  // Mostly well-formed strings of random characters, some corrupted, some noise
  task automatic test_random_strings(input int n_bytes);
    byte_q_t    s;
    int         first;
    int         pick;
    int         len;
    logic [7:0] lead;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      no_gaps = (bytes_sent - first >= 150) && (bytes_sent - first < 300);
      s = {};
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 6)) append_byte(s, 8'($urandom));
      end else begin
        if ($urandom_range(0, 9) == 0) s = {8'hEF, 8'hBB, 8'hBF};
        repeat ($urandom_range(1, 6)) begin
          pick = $urandom_range(0, 99);
          len  = (pick < 40) ? 1 : (pick < 65) ? 2 : (pick < 85) ? 3 :
                 (pick < 93) ? 4 : (pick < 97) ? 5 : 6;
          case (len)
            1: lead = {1'b0, 7'($urandom)};
            2: lead = {3'b110, 5'($urandom)};
            3: lead = ($urandom_range(0, 4) == 0) ? 8'hED : {4'b1110, 4'($urandom)};
            4: lead = {5'b11110, 3'($urandom)};
            5: lead = {6'b111110, 2'($urandom)};
            default: lead = {7'b1111110, 1'($urandom)};
          endcase
          append_byte(s, lead);
          repeat (len - 1) append_byte(s, {2'b10, 6'($urandom)});
        end
        // occasional damage: cut the tail or overwrite one byte
        pick = $urandom_range(0, 99);
        if (pick < 8 && s.size() > 1) s.pop_back();
        else if (pick < 14) s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
      end
      send_string(s);
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_decoder();
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ascii_extremes();
    test_bom();
    test_forbidden_lead();
    test_bad_lead();
    test_bad_continuation();
    test_truncation();
    test_surrogate();
    test_beyond_bmp();
    test_random_strings(RANDOM_BYTES);

    in_valid <= 1'b0;
    while (ucs2_out_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d bytes in %0d strings; %0d result transfers checked, %0d characters.",
             bytes_sent, strings_sent, results_checked, chars_predicted);
    $display("String endings: ok %0d, forbidden %0d, bad lead %0d, bad cont %0d, trunc %0d, surr %0d",
             status_seen[ST_OK], status_seen[ST_FORBIDDEN], status_seen[ST_BAD_LEAD],
             status_seen[ST_BAD_CONT], status_seen[ST_TRUNC], status_seen[ST_SURROGATE]);
    if (errors == 0) begin
      $display("utf8_to_ucs2_decoder_core verification clean");
    end else begin
      $display("utf8_to_ucs2_decoder_core verification failed");
    end
    $finish;
  end

endmodule
